### sv/cffba_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and widths for the first-fit contiguous block allocator
// no dependencies
package cffba_pkg;

   localparam int NUM_BLOCKS_DEF = 512;
   localparam int MAX_FILES_DEF  = 8;

   localparam int KIND_W   = 2;
   localparam int FILE_W   = 3;
   localparam int COUNT_W  = 10;
   localparam int STATUS_W = 3;
   localparam int START_W  = 9;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_WRITTEN = 3'd0,
      ST_READ    = 3'd1,
      ST_DELETED = 3'd2,
      ST_MISSING = 3'd3,
      ST_NOSPACE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_MARK,
      S_FREE,
      S_DONE
   } fsm_state_type;

endpackage

### sv/contiguous_first_fit_block_allocator.sv
`timescale 1ns / 1ps
// First-fit contiguous block allocator.
// A request (req_*) names an operation, a file number, a block count and whether
// the backing file exists; one response (rsp_*) per request gives a status, the
// start block and the run length. Both channels use valid/stall; a request is
// taken when req_valid is high and req_stall low, likewise for the response.
// The block owner map sits in a ram of NUM_BLOCKS entries and the per-file
// start/length table in a ram of MAX_FILES entries with a valid flop per file.
// After reset a clearing pass writes every map entry to free, one per cycle,
// while req_stall stays high.
// One request is worked on at a time. A file with a table entry (not a delete),
// or an invalid file number, goes from S_DECIDE to S_DONE. A new file runs a
// first-fit scan over the map at one entry per cycle, then for a write or a
// present read marks the run at one block per cycle; a delete of an existing
// file frees its run at one block per cycle. The map ram port sets these rates.
// The response sits in an output register; a new request is taken while it
// waits under rsp_stall, and the next result waits until that one is taken.
module contiguous_first_fit_block_allocator #(
   parameter int NUM_BLOCKS = cffba_pkg::NUM_BLOCKS_DEF,
   parameter int MAX_FILES  = cffba_pkg::MAX_FILES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [cffba_pkg::KIND_W-1:0]   req_kind,
   input  logic [cffba_pkg::FILE_W-1:0]   req_file_id,
   input  logic [cffba_pkg::COUNT_W-1:0]  req_block_count,
   input  logic                           req_file_present,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [cffba_pkg::STATUS_W-1:0] rsp_status,
   output logic [cffba_pkg::START_W-1:0]  rsp_start_block,
   output logic [cffba_pkg::COUNT_W-1:0]  rsp_run_length
);

   localparam int AW   = $clog2(NUM_BLOCKS);
   localparam int FW   = $clog2(MAX_FILES);
   localparam int CW   = cffba_pkg::COUNT_W;
   localparam int SW   = ((AW > CW) ? AW : CW) + 1;
   localparam int EW   = AW + CW;
   localparam logic [AW-1:0] LAST = AW'(NUM_BLOCKS - 1);

   cffba_pkg::fsm_state_type state_ff, state_in;

   logic [cffba_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [cffba_pkg::FILE_W-1:0] fid_ff, fid_in;
   logic [CW-1:0]                need_ff, need_in;
   logic                         present_ff, present_in;
   logic                         fid_ok_ff, fid_ok_in;
   logic [FW-1:0]                idx;

   logic [MAX_FILES-1:0] entry_vld_ff, entry_vld_in;

   logic [AW-1:0] scan_ff, scan_in;
   logic [AW-1:0] chk_ff, chk_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [CW-1:0] run_ff, run_in;
   logic [CW-1:0] run_next;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [SW-1:0] fit_start_w;
   logic [AW-1:0] fit_start;

   cffba_pkg::status_type res_status_ff, res_status_in;
   logic [AW-1:0]         res_start_ff, res_start_in;
   logic [CW-1:0]         res_len_ff, res_len_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [cffba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [cffba_pkg::START_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [CW-1:0]                  rsp_len_ff, rsp_len_in;

   logic                         own_we;
   logic [AW-1:0]                own_waddr;
   logic [cffba_pkg::FILE_W-1:0] own_wdata;
   logic [cffba_pkg::FILE_W-1:0] own_rdata;

   logic          ent_we;
   logic [EW-1:0] ent_wdata;
   logic [EW-1:0] ent_rdata;
   logic [AW-1:0] ent_start;
   logic [CW-1:0] ent_len;
   logic          entry_hit;
   logic          keep_run;

   cffba_ram #(
      .WIDTH (cffba_pkg::FILE_W),
      .DEPTH (NUM_BLOCKS)
   ) u_owner_ram (
      .clock   (clock),
      .wr_en   (own_we),
      .wr_addr (own_waddr),
      .wr_data (own_wdata),
      .rd_addr (scan_ff),
      .rd_data (own_rdata)
   );

   cffba_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_FILES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (idx),
      .wr_data (ent_wdata),
      .rd_addr (FW'(req_file_id)),
      .rd_data (ent_rdata)
   );

   assign idx       = FW'(fid_ff);
   assign ent_start = ent_rdata[EW-1:CW];
   assign ent_len   = ent_rdata[CW-1:0];
   assign entry_hit = fid_ok_ff && entry_vld_ff[idx];
   assign ent_wdata = {fit_start, need_ff};

   // start of the run that ends at the block now being checked
   assign run_next    = run_ff + CW'(1);
   assign fit_start_w = SW'(chk_ff) + SW'(1) - SW'(need_ff);
   assign fit_start   = AW'(fit_start_w);
   assign keep_run    = (kind_ff == cffba_pkg::KIND_WRITE) ||
                        ((kind_ff == cffba_pkg::KIND_READ) && present_ff);

   assign req_stall       = (state_ff != cffba_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_block = rsp_start_ff;
   assign rsp_run_length  = rsp_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cffba_pkg::S_CLEAR;
         entry_vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
         wr_addr_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         entry_vld_ff <= entry_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_addr_ff   <= wr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      fid_ff        <= fid_in;
      need_ff       <= need_in;
      present_ff    <= present_in;
      fid_ok_ff     <= fid_ok_in;
      scan_ff       <= scan_in;
      chk_ff        <= chk_in;
      chk_vld_ff    <= chk_vld_in;
      run_ff        <= run_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_len_ff    <= rsp_len_in;
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      fid_in        = fid_ff;
      need_in       = need_ff;
      present_in    = present_ff;
      fid_ok_in     = fid_ok_ff;
      entry_vld_in  = entry_vld_ff;
      scan_in       = scan_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      run_in        = run_ff;
      wr_addr_in    = wr_addr_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_len_in    = res_len_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_len_in    = rsp_len_ff;
      own_we        = 1'b0;
      own_waddr     = wr_addr_ff;
      own_wdata     = '0;
      ent_we        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         cffba_pkg::S_CLEAR: begin
            own_we     = 1'b1;
            wr_addr_in = wr_addr_ff + AW'(1);
            if (wr_addr_ff == LAST) begin
               wr_addr_in = '0;
               state_in   = cffba_pkg::S_IDLE;
            end
         end
         cffba_pkg::S_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               fid_in     = req_file_id;
               need_in    = req_block_count;
               present_in = req_file_present;
               fid_ok_in  = (req_file_id != '0) && (int'(req_file_id) < MAX_FILES);
               state_in   = cffba_pkg::S_DECIDE;
            end
         end
         cffba_pkg::S_DECIDE: begin
            res_status_in = cffba_pkg::ST_MISSING;
            res_start_in  = '0;
            res_len_in    = '0;
            state_in      = cffba_pkg::S_DONE;
            scan_in       = '0;
            chk_vld_in    = 1'b0;
            run_in        = '0;
            if (entry_hit) begin
               if (kind_ff == cffba_pkg::KIND_WRITE) begin
                  res_status_in = cffba_pkg::ST_WRITTEN;
                  res_start_in  = ent_start;
                  res_len_in    = ent_len;
               end else if (present_ff && kind_ff == cffba_pkg::KIND_READ) begin
                  res_status_in = cffba_pkg::ST_READ;
                  res_start_in  = ent_start;
                  res_len_in    = ent_len;
               end else if (present_ff) begin
                  res_status_in     = cffba_pkg::ST_DELETED;
                  res_start_in      = ent_start;
                  res_len_in        = ent_len;
                  entry_vld_in[idx] = 1'b0;
                  wr_addr_in        = ent_start;
                  cnt_in            = ent_len;
                  state_in          = cffba_pkg::S_FREE;
               end
            end else if (fid_ok_ff) begin
               if (need_ff == '0) begin
                  res_status_in = cffba_pkg::ST_NOSPACE;
               end else begin
                  state_in = cffba_pkg::S_SCAN;
               end
            end
         end
         cffba_pkg::S_SCAN: begin
            // read address runs one ahead of the block being checked
            if (scan_ff != LAST) begin
               scan_in = scan_ff + AW'(1);
            end
            chk_in     = scan_ff;
            chk_vld_in = 1'b1;
            if (chk_vld_ff) begin
               if (own_rdata == '0) begin
                  run_in = run_next;
               end else begin
                  run_in = '0;
               end
               if (own_rdata == '0 && run_next == need_ff) begin
                  if (keep_run) begin
                     ent_we            = 1'b1;
                     entry_vld_in[idx] = 1'b1;
                     res_status_in     = (kind_ff == cffba_pkg::KIND_WRITE) ?
                                         cffba_pkg::ST_WRITTEN : cffba_pkg::ST_READ;
                     res_start_in      = fit_start;
                     res_len_in        = need_ff;
                     wr_addr_in        = fit_start;
                     cnt_in            = need_ff;
                     state_in          = cffba_pkg::S_MARK;
                  end else if (present_ff) begin
                     // taken and given back at once: map is left as it was
                     res_status_in = cffba_pkg::ST_DELETED;
                     res_start_in  = fit_start;
                     res_len_in    = need_ff;
                     state_in      = cffba_pkg::S_DONE;
                  end else begin
                     res_status_in = cffba_pkg::ST_MISSING;
                     res_start_in  = '0;
                     res_len_in    = '0;
                     state_in      = cffba_pkg::S_DONE;
                  end
               end else if (chk_ff == LAST) begin
                  res_status_in = cffba_pkg::ST_NOSPACE;
                  res_start_in  = '0;
                  res_len_in    = '0;
                  state_in      = cffba_pkg::S_DONE;
               end
            end
         end
         cffba_pkg::S_MARK: begin
            own_we     = 1'b1;
            own_wdata  = fid_ff;
            wr_addr_in = wr_addr_ff + AW'(1);
            cnt_in     = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = cffba_pkg::S_DONE;
            end
         end
         cffba_pkg::S_FREE: begin
            own_we     = 1'b1;
            wr_addr_in = wr_addr_ff + AW'(1);
            cnt_in     = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = cffba_pkg::S_DONE;
            end
         end
         cffba_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = cffba_pkg::START_W'(res_start_ff);
               rsp_len_in    = res_len_ff;
               state_in      = cffba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cffba_pkg::S_IDLE;
         end
      endcase
   end

   a_rsp_only_from_done: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && state_ff != cffba_pkg::S_DONE) |=> !rsp_valid_ff)
      else $error("response appeared without a finished request");

   a_error_carries_no_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == cffba_pkg::ST_MISSING ||
                     rsp_status == cffba_pkg::ST_NOSPACE))
      |-> (rsp_start_block == '0 && rsp_run_length == '0))
      else $error("error response carries a run");

   a_mark_owner_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cffba_pkg::S_MARK) |-> (own_we && own_wdata != '0 && cnt_ff != '0))
      else $error("marking a run with the free owner");

   a_free_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cffba_pkg::S_FREE) |-> (cnt_ff != '0))
      else $error("freeing with an empty count");

endmodule

### sv/cffba_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
module cffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### bench/contiguous_first_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// self-checking bench for contiguous_first_fit_block_allocator: directed and random requests
// against an in-bench allocation predictor, with random idling on both channels
// depends on cffba_pkg and the allocator rtl
module contiguous_first_fit_block_allocator_tb;

   localparam int NUM_BLOCKS = cffba_pkg::NUM_BLOCKS_DEF;
   localparam int MAX_FILES  = cffba_pkg::MAX_FILES_DEF;
   localparam int KIND_W     = cffba_pkg::KIND_W;
   localparam int FILE_W     = cffba_pkg::FILE_W;
   localparam int COUNT_W    = cffba_pkg::COUNT_W;
   localparam int STATUS_W   = cffba_pkg::STATUS_W;
   localparam int START_W    = cffba_pkg::START_W;
   localparam logic [KIND_W-1:0] KIND_WRITE  = cffba_pkg::KIND_WRITE;
   localparam logic [KIND_W-1:0] KIND_READ   = cffba_pkg::KIND_READ;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
   localparam int QUIET_LIMIT = 20000;

   typedef struct packed {
      cffba_pkg::status_type status;
      logic [START_W-1:0]    start_block;
      logic [COUNT_W-1:0]    run_length;
   } alloc_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [FILE_W-1:0]   req_file_id = '0;
   logic [COUNT_W-1:0]  req_block_count = '0;
   logic                req_file_present = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [START_W-1:0]  rsp_start_block;
   logic [COUNT_W-1:0]  rsp_run_length;

   // predictor state
   logic [FILE_W-1:0]  owner_map [NUM_BLOCKS];
   logic [START_W-1:0] file_start [MAX_FILES];
   logic [COUNT_W-1:0] file_length [MAX_FILES];

   alloc_result_type pending_results [$];
   int error_count = 0;
   int quiet_cycles = 0;

   // sender and receiver pacing
   bit sender_idles = 1'b1;
   int burst_left = 0;
   int stall_pct = 30;
   int holdoff_req = 0;
   int hold_left = 0;
   int stall_run = 0;

   contiguous_first_fit_block_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_file_id      (req_file_id),
      .req_block_count  (req_block_count),
      .req_file_present (req_file_present),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_start_block  (rsp_start_block),
      .rsp_run_length   (rsp_run_length)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic alloc_result_type predict_allocation(logic [KIND_W-1:0] kind,
         logic [FILE_W-1:0] fid, logic [COUNT_W-1:0] need, logic present);
      alloc_result_type res;
      int run;
      int first;
      int b;
      bit found;
      res.status = cffba_pkg::ST_MISSING;
      res.start_block = '0;
      res.run_length = '0;
      run = 0;
      first = 0;
      found = 1'b0;
      if (fid == 0 || fid >= MAX_FILES) return res;
      if (file_length[fid] != 0) begin
         if (kind != KIND_WRITE && !present) return res;
         res.start_block = file_start[fid];
         res.run_length = file_length[fid];
         if (kind == KIND_WRITE) begin
            res.status = cffba_pkg::ST_WRITTEN;
         end else if (kind == KIND_READ) begin
            res.status = cffba_pkg::ST_READ;
         end else begin
            for (b = file_start[fid]; b < file_start[fid] + file_length[fid] && b < NUM_BLOCKS;
                 b++)
               owner_map[b] = '0;
            file_start[fid] = '0;
            file_length[fid] = '0;
            res.status = cffba_pkg::ST_DELETED;
         end
         return res;
      end
      if (need != 0) begin
         for (b = 0; b < NUM_BLOCKS && !found; b++) begin
            if (owner_map[b] == 0) begin
               run++;
               if (run == need) begin
                  found = 1'b1;
                  first = b + 1 - need;
               end
            end else begin
               run = 0;
            end
         end
      end
      if (!found) begin
         res.status = cffba_pkg::ST_NOSPACE;
         return res;
      end
      res.start_block = START_W'(first);
      res.run_length = need;
      if (kind == KIND_WRITE || (kind == KIND_READ && present)) begin
         for (b = first; b < first + need; b++)
            owner_map[b] = fid;
         file_start[fid] = START_W'(first);
         file_length[fid] = need;
         res.status = (kind == KIND_WRITE) ? cffba_pkg::ST_WRITTEN : cffba_pkg::ST_READ;
      end else if (present) begin
         // run is taken and released in one go, the map ends up unchanged
         res.status = cffba_pkg::ST_DELETED;
      end else begin
         res.start_block = '0;
         res.run_length = '0;
      end
      return res;
   endfunction

   function automatic logic [COUNT_W-1:0] pick_block_count();
      int r;
      r = $urandom_range(99);
      if (r < 70) return COUNT_W'($urandom_range(32, 1));
      if (r < 90) return COUNT_W'($urandom_range(200, 33));
      if (r < 97) return COUNT_W'($urandom_range(512, 201));
      if (r < 98) return '0;
      return COUNT_W'($urandom_range(1023, 513));
   endfunction

   // called just after a rising edge; returns at the edge the request is taken
   task automatic issue_request(logic [KIND_W-1:0] kind, logic [FILE_W-1:0] fid,
         logic [COUNT_W-1:0] count, logic present);
      int gap;
      if (sender_idles && burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         gap = $urandom_range(8, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_kind <= kind;
      req_file_id <= fid;
      req_block_count <= count;
      req_file_present <= present;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(predict_allocation(kind, fid, count, present));
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // mostly well-formed file lifecycles, with some noise mixed in
   task automatic issue_lifecycle_step();
      logic [FILE_W-1:0] fid;
      int r;
      fid = FILE_W'($urandom_range(MAX_FILES - 1, 1));
      r = $urandom_range(99);
      if (r < 12) begin
         issue_request(KIND_W'($urandom_range(3)), FILE_W'($urandom_range(7)),
                       pick_block_count(), 1'($urandom_range(1)));
      end else if (file_length[fid] == 0) begin
         issue_request(KIND_WRITE, fid, pick_block_count(), 1'($urandom_range(1)));
      end else if (r < 50) begin
         issue_request(KIND_READ, fid, pick_block_count(), 1'b1);
      end else if (r < 60) begin
         issue_request(KIND_WRITE, fid, pick_block_count(), 1'($urandom_range(1)));
      end else if (r < 90) begin
         issue_request(KIND_DELETE, fid, pick_block_count(), 1'b1);
      end else begin
         issue_request($urandom_range(1) ? KIND_READ : KIND_DELETE, fid,
                       pick_block_count(), 1'b0);
      end
   endtask

   task automatic test_directed();
      issue_request(KIND_WRITE, 3'd1, 10'd1, 1'b1);
      issue_request(KIND_WRITE, 3'd1, 10'd5, 1'b0);
      issue_request(KIND_READ, 3'd1, 10'd5, 1'b1);
      issue_request(KIND_READ, 3'd1, 10'd5, 1'b0);
      issue_request(KIND_DELETE, 3'd1, 10'd5, 1'b0);
      issue_request(KIND_DELETE, 3'd1, 10'd5, 1'b1);
      // zero count and over-size count cannot be placed
      issue_request(KIND_WRITE, 3'd2, 10'd0, 1'b1);
      issue_request(KIND_WRITE, 3'd3, 10'd1023, 1'b1);
      // whole map to one file, then nothing fits
      issue_request(KIND_WRITE, 3'd7, 10'd512, 1'b1);
      issue_request(KIND_WRITE, 3'd4, 10'd1, 1'b1);
      issue_request(KIND_SPARE, 3'd7, 10'd1, 1'b1);
      issue_request(KIND_WRITE, 3'd0, 10'd4, 1'b1);
      // new file read keeps its run, new file delete gives it back
      issue_request(KIND_READ, 3'd5, 10'd10, 1'b1);
      issue_request(KIND_DELETE, 3'd5, 10'd10, 1'b0);
      issue_request(KIND_DELETE, 3'd6, 10'd3, 1'b1);
      issue_request(KIND_DELETE, 3'd6, 10'd3, 1'b0);
      issue_request(KIND_READ, 3'd6, 10'd3, 1'b0);
      // punch a hole and refill it first-fit
      issue_request(KIND_WRITE, 3'd1, 10'd10, 1'b1);
      issue_request(KIND_WRITE, 3'd2, 10'd20, 1'b1);
      issue_request(KIND_WRITE, 3'd3, 10'd30, 1'b1);
      issue_request(KIND_DELETE, 3'd2, 10'd1, 1'b1);
      issue_request(KIND_WRITE, 3'd4, 10'd15, 1'b0);
      issue_request(KIND_WRITE, 3'd6, 10'd30, 1'b1);
      issue_request(KIND_SPARE, 3'd3, 10'd1, 1'b0);
      issue_request(KIND_SPARE, 3'd2, 10'd7, 1'b0);
      wait_all_results();
   endtask

   task automatic test_fragmentation();
      int f;
      int k;
      for (f = 1; f < MAX_FILES; f++)
         issue_request(KIND_DELETE, FILE_W'(f), 10'd1, 1'b1);
      for (f = 1; f < MAX_FILES; f++)
         issue_request(KIND_WRITE, FILE_W'(f), COUNT_W'($urandom_range(72, 64)), 1'b1);
      for (k = 0; k < 3; k++)
         issue_request(KIND_DELETE, FILE_W'($urandom_range(MAX_FILES - 1, 1)), 10'd1, 1'b1);
      for (k = 0; k < 6; k++)
         issue_request(KIND_WRITE, FILE_W'($urandom_range(MAX_FILES - 1, 1)),
                       COUNT_W'($urandom_range(100, 1)), 1'b1);
      issue_request(KIND_READ, FILE_W'($urandom_range(MAX_FILES - 1, 1)), 10'd512, 1'b1);
      for (f = 1; f < MAX_FILES; f++)
         issue_request(KIND_DELETE, FILE_W'(f), 10'd1, 1'b1);
      issue_request(KIND_WRITE, 3'd1, 10'd512, 1'b1);
      issue_request(KIND_DELETE, 3'd1, 10'd512, 1'b1);
      wait_all_results();
   endtask

   task automatic test_lifecycles(int n);
      int k;
      for (k = 0; k < n; k++) begin
         if (k % 150 == 0) stall_pct = $urandom_range(70);
         issue_lifecycle_step();
      end
      wait_all_results();
   endtask

   task automatic test_backpressure();
      int k;
      sender_idles = 1'b0;
      holdoff_req = 3000;
      for (k = 0; k < 12; k++)
         issue_request(KIND_READ, FILE_W'($urandom_range(MAX_FILES - 1, 1)),
                       COUNT_W'($urandom_range(8, 1)), 1'b1);
      wait_all_results();
      sender_idles = 1'b1;
   endtask

   task automatic test_random_fields(int n);
      int k;
      for (k = 0; k < n; k++)
         issue_request(KIND_W'($urandom_range(3)), FILE_W'($urandom_range(7)),
                       pick_block_count(), 1'($urandom_range(1)));
      wait_all_results();
   endtask

   task automatic test_streaming(int n);
      int k;
      sender_idles = 1'b0;
      stall_pct = 0;
      for (k = 0; k < n; k++)
         issue_lifecycle_step();
      wait_all_results();
      sender_idles = 1'b1;
      stall_pct = 30;
   endtask

   initial begin
      for (int b = 0; b < NUM_BLOCKS; b++) owner_map[b] = '0;
      for (int f = 0; f < MAX_FILES; f++) begin
         file_start[f] = '0;
         file_length[f] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fragmentation();
      test_lifecycles(650);
      test_backpressure();
      test_random_fields(300);
      test_streaming(150);
      repeat (64) @(posedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // receiver: random stall runs, plus a long hold-off on request
   always @(posedge clock) begin
      if (holdoff_req != 0) begin
         hold_left = holdoff_req;
         holdoff_req = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_run != 0) begin
         stall_run--;
      end else begin
         stall_run = $urandom_range(5);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      alloc_result_type exp_res;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: status %0d start %0d length %0d",
                   rsp_status, rsp_start_block, rsp_run_length);
            error_count++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_status !== exp_res.status) begin
               $error("status: expected %0d, got %0d", exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_start_block !== exp_res.start_block) begin
               $error("start_block: expected %0d, got %0d", exp_res.start_block,
                      rsp_start_block);
               error_count++;
            end
            if (rsp_run_length !== exp_res.run_length) begin
               $error("run_length: expected %0d, got %0d", exp_res.run_length,
                      rsp_run_length);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

endmodule
